/* sv/mlr_pkg.sv */
// shared types, constants and octant mapping functions for the line rasterizer
package mlr_pkg;

  localparam int COORD_BITS  = 11;
  localparam int ZW          = COORD_BITS + 1;
  localparam int EW          = COORD_BITS + 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [ZW-1:0]         zcoord_t;
  typedef logic signed [EW-1:0]         err_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ZONE_0 = 3'd0,
    ZONE_1 = 3'd1,
    ZONE_2 = 3'd2,
    ZONE_3 = 3'd3,
    ZONE_4 = 3'd4,
    ZONE_5 = 3'd5,
    ZONE_6 = 3'd6,
    ZONE_7 = 3'd7
  } octant_t;

  typedef struct packed {
    zcoord_t a;
    zcoord_t b;
  } zpair_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } cpair_t;

  // word handed from the front end to the walker
  typedef struct packed {
    cmd_t    cmd;
    octant_t oct;
    zpair_t  p1;
    zpair_t  p2;
  } qword_t;

  // octant of the vector (dx, dy)
  function automatic octant_t pick_zone(zcoord_t dx, zcoord_t dy);
    zcoord_t ax;
    zcoord_t ay;
    octant_t z;
    ax = dx[ZW-1] ? -dx : dx;
    ay = dy[ZW-1] ? -dy : dy;
    if (dx >= zcoord_t'(0) && dy >= zcoord_t'(0)) begin
      z = (ax >= ay) ? ZONE_0 : ZONE_1;
    end else if (dx <= zcoord_t'(0) && dy >= zcoord_t'(0)) begin
      z = (ay >= ax) ? ZONE_2 : ZONE_3;
    end else if (dx <= zcoord_t'(0) && dy <= zcoord_t'(0)) begin
      z = (ax >= ay) ? ZONE_4 : ZONE_5;
    end else begin
      z = (ay >= ax) ? ZONE_6 : ZONE_7;
    end
    return z;
  endfunction

  // map a point of the given octant into octant zero
  function automatic zpair_t into_zero(octant_t z, coord_t x, coord_t y);
    zcoord_t xs;
    zcoord_t ys;
    zpair_t  r;
    xs = zcoord_t'(x);
    ys = zcoord_t'(y);
    case (z)
      ZONE_0:  begin r.a = xs;  r.b = ys;  end
      ZONE_1:  begin r.a = ys;  r.b = xs;  end
      ZONE_2:  begin r.a = ys;  r.b = -xs; end
      ZONE_3:  begin r.a = -xs; r.b = ys;  end
      ZONE_4:  begin r.a = -xs; r.b = -ys; end
      ZONE_5:  begin r.a = -ys; r.b = -xs; end
      ZONE_6:  begin r.a = -ys; r.b = xs;  end
      default: begin r.a = xs;  r.b = -ys; end
    endcase
    return r;
  endfunction

  // map an octant-zero point back, truncated to coordinate width
  function automatic cpair_t out_of_zero(octant_t z, zcoord_t a, zcoord_t b);
    zcoord_t x;
    zcoord_t y;
    cpair_t  r;
    case (z)
      ZONE_0:  begin x = a;  y = b;  end
      ZONE_1:  begin x = b;  y = a;  end
      ZONE_2:  begin x = -b; y = a;  end
      ZONE_3:  begin x = -a; y = b;  end
      ZONE_4:  begin x = -a; y = -b; end
      ZONE_5:  begin x = -b; y = -a; end
      ZONE_6:  begin x = b;  y = -a; end
      default: begin x = a;  y = -b; end
    endcase
    r.x = x[COORD_BITS-1:0];
    r.y = y[COORD_BITS-1:0];
    return r;
  endfunction

endpackage

/* sv/mlr_front.sv */
// front end: takes input words, finds the octant and maps endpoints into octant zero
module mlr_front import mlr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   cmd,
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t end_x,
  input  coord_t end_y,
  output logic   push_valid,
  input  logic   push_ready,
  output qword_t push_data
);

  logic   hold_valid;
  logic   hold_valid_next;
  cmd_t   hold_cmd;
  coord_t hold_sx;
  coord_t hold_sy;
  coord_t hold_ex;
  coord_t hold_ey;

  zcoord_t dx;
  zcoord_t dy;
  octant_t zone;

  // input holding register
  assign in_ready = !hold_valid || push_ready;

  always_comb begin
    hold_valid_next = hold_valid;
    if (in_valid && in_ready) begin
      hold_valid_next = 1'b1;
    end else if (push_ready) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_cmd <= cmd_t'(cmd);
      hold_sx  <= start_x;
      hold_sy  <= start_y;
      hold_ex  <= end_x;
      hold_ey  <= end_y;
    end
  end

  // octant classification and mapping of both endpoints
  assign dx   = zcoord_t'(hold_ex) - zcoord_t'(hold_sx);
  assign dy   = zcoord_t'(hold_ey) - zcoord_t'(hold_sy);
  assign zone = pick_zone(dx, dy);

  always_comb begin
    push_data.cmd = hold_cmd;
    push_data.oct = zone;
    push_data.p1  = into_zero(zone, hold_sx, hold_sy);
    push_data.p2  = into_zero(zone, hold_ex, hold_ey);
  end

  assign push_valid = hold_valid;

endmodule

/* sv/mlr_queue.sv */
// short fifo between the front end and the walker
module mlr_queue import mlr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  qword_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output qword_t pop_data
);

  qword_t              slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QPTR_W-1:0]   wr_ptr_next;
  logic [QPTR_W-1:0]   rd_ptr_next;
  logic [QCNT_W-1:0]   count_next;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != QCNT_W'(0));
  assign pop_data   = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0) : wr_ptr + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0) : rd_ptr + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_next = count + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

/* sv/mlr_back.sv */
// walker: keeps the midpoint state, steps the line and registers each pixel word
module mlr_back import mlr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   pop_valid,
  output logic   pop_ready,
  input  qword_t pop_data,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   pix_valid,
  output coord_t pix_x,
  output coord_t pix_y,
  output logic   pix_last
);

  zcoord_t walk_x;
  zcoord_t walk_y;
  zcoord_t stop_x;
  err_t    err_term;
  err_t    inc_east;
  err_t    inc_northeast;
  octant_t octant;
  logic    line_active;

  zcoord_t walk_x_next;
  zcoord_t walk_y_next;
  zcoord_t stop_x_next;
  err_t    err_term_next;
  err_t    inc_east_next;
  err_t    inc_northeast_next;
  octant_t octant_next;
  logic    line_active_next;

  logic    out_valid_next;
  logic    res_valid;
  logic    res_last;
  cpair_t  res_pix;
  err_t    dx;
  err_t    dy;
  logic    do_pop;

  assign pop_ready = !out_valid || out_ready;
  assign do_pop    = pop_valid && pop_ready;

  // line state update and pixel for the popped word
  always_comb begin
    walk_x_next        = walk_x;
    walk_y_next        = walk_y;
    stop_x_next        = stop_x;
    err_term_next      = err_term;
    inc_east_next      = inc_east;
    inc_northeast_next = inc_northeast;
    octant_next        = octant;
    line_active_next   = line_active;
    dx                 = err_t'(pop_data.p2.a) - err_t'(pop_data.p1.a);
    dy                 = err_t'(pop_data.p2.b) - err_t'(pop_data.p1.b);
    res_valid          = 1'b0;
    res_last           = 1'b0;
    res_pix            = '0;
    case (pop_data.cmd)
      CMD_LOAD: begin
        walk_x_next        = pop_data.p1.a;
        walk_y_next        = pop_data.p1.b;
        stop_x_next        = pop_data.p2.a;
        err_term_next      = (dy <<< 1) - dx;
        inc_east_next      = dy <<< 1;
        inc_northeast_next = (dy - dx) <<< 1;
        octant_next        = pop_data.oct;
        line_active_next   = pop_data.p1.a < pop_data.p2.a;
        res_valid          = 1'b1;
        res_last           = !line_active_next;
        res_pix            = out_of_zero(pop_data.oct, pop_data.p1.a, pop_data.p1.b);
      end
      default: begin
        if (line_active) begin
          walk_x_next = walk_x + zcoord_t'(1);
          if (err_term[EW-1]) begin
            err_term_next = err_term + inc_east;
          end else begin
            walk_y_next   = walk_y + zcoord_t'(1);
            err_term_next = err_term + inc_northeast;
          end
          line_active_next = walk_x_next < stop_x;
          res_valid        = 1'b1;
          res_last         = !line_active_next;
          res_pix          = out_of_zero(octant, walk_x_next, walk_y_next);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_x        <= '0;
      walk_y        <= '0;
      stop_x        <= '0;
      err_term      <= '0;
      inc_east      <= '0;
      inc_northeast <= '0;
      octant        <= ZONE_0;
      line_active   <= 1'b0;
    end else if (do_pop) begin
      walk_x        <= walk_x_next;
      walk_y        <= walk_y_next;
      stop_x        <= stop_x_next;
      err_term      <= err_term_next;
      inc_east      <= inc_east_next;
      inc_northeast <= inc_northeast_next;
      octant        <= octant_next;
      line_active   <= line_active_next;
    end
  end

  // output register
  always_comb begin
    out_valid_next = out_valid;
    if (do_pop) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      pix_valid <= res_valid;
      pix_x     <= res_pix.x;
      pix_y     <= res_pix.y;
      pix_last  <= res_last;
    end
  end

endmodule

/* sv/midpoint_line_rasterizer.sv */
// midpoint line rasterizer over eight octants, top level
// path: a word accepted at the input passes the front end holding register, then a queue slot,
// then the walker output register, and is taken from the outputs when out_ready is high
// throughput: one word per cycle while out_ready stays high
// the front end register, the two-entry queue and the walker output register pipeline the path
// reset: synchronous, active high; clears the queue, all line state and leaves no line active
module midpoint_line_rasterizer import mlr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   cmd,
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t end_x,
  input  coord_t end_y,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   pix_valid,
  output coord_t pix_x,
  output coord_t pix_y,
  output logic   pix_last
);

  logic   push_valid;
  logic   push_ready;
  qword_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  qword_t pop_data;

  // classify and map
  mlr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoupling queue
  mlr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // walk the line
  mlr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pix_valid (pix_valid),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_last  (pix_last)
  );

`ifndef ASSERT_OFF
  // an idle step word carries all zero fields
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pix_valid |-> pix_x == '0 && pix_y == '0 && !pix_last)
    else $error("idle step word has nonzero fields");

  // the last flag only rides on a real pixel
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && pix_last |-> pix_valid)
    else $error("last flag without pixel");

  // a load always gives a pixel on the next cycle
  a_load_pixel: assert property (@(posedge clk) disable iff (rst)
    pop_valid && pop_ready && pop_data.cmd == CMD_LOAD |=> out_valid && pix_valid)
    else $error("load did not produce a pixel");
`endif

endmodule

/* dv/tb_midpoint_line_rasterizer.sv */
// self-checking testbench for the eight-octant midpoint line rasterizer
`timescale 1ns / 1ps

module tb_midpoint_line_rasterizer;
  import mlr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 980;
  localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;

  typedef struct {
    logic   shown;
    coord_t x;
    coord_t y;
    logic   ends;
  } pixel_word_t;

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   in_ready;
  logic   cmd       = CMD_LOAD;
  coord_t start_x   = '0;
  coord_t start_y   = '0;
  coord_t end_x     = '0;
  coord_t end_y     = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   pix_valid;
  coord_t pix_x;
  coord_t pix_y;
  logic   pix_last;

  midpoint_line_rasterizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pix_valid (pix_valid),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_last  (pix_last)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // line walker state, kept in octant zero
  zcoord_t walk_a;
  zcoord_t walk_b;
  zcoord_t walk_stop;
  err_t    decision;
  err_t    grow_east;
  err_t    grow_ne;
  octant_t line_zone;
  logic    line_open = 1'b0;

  pixel_word_t expected_pixels[$];
  logic        idle_on = 1'b1;
  int          fault_count    = 0;
  int          cycle_count    = 0;
  int          work_words     = 0;
  int          loads_seen     = 0;
  int          idle_steps     = 0;
  int          pixels_checked = 0;
  int          ends_checked   = 0;
  int          zone_hits[8];

  // octant of the vector from start to end; ties go to the lower-numbered zone
  function automatic octant_t zone_of(zcoord_t dx, zcoord_t dy);
    zcoord_t mag_x;
    zcoord_t mag_y;
    mag_x = (dx < 0) ? -dx : dx;
    mag_y = (dy < 0) ? -dy : dy;
    if (dy >= 0) begin
      if (dx >= 0) return (mag_x >= mag_y) ? ZONE_0 : ZONE_1;
      return (mag_y >= mag_x) ? ZONE_2 : ZONE_3;
    end
    if (dx <= 0) return (mag_x >= mag_y) ? ZONE_4 : ZONE_5;
    return (mag_y >= mag_x) ? ZONE_6 : ZONE_7;
  endfunction

  // rotate / reflect a point of octant z onto octant zero
  function automatic void fold_point(input octant_t z, input zcoord_t x, input zcoord_t y,
                                     output zcoord_t a, output zcoord_t b);
    case (z)
      ZONE_0: begin a = x;  b = y;  end
      ZONE_1: begin a = y;  b = x;  end
      ZONE_2: begin a = y;  b = -x; end
      ZONE_3: begin a = -x; b = y;  end
      ZONE_4: begin a = -x; b = -y; end
      ZONE_5: begin a = -y; b = -x; end
      ZONE_6: begin a = -y; b = x;  end
      default: begin a = x; b = -y; end
    endcase
  endfunction

  // inverse of fold_point, cut to the coordinate width
  function automatic pixel_word_t current_pixel(logic ends);
    zcoord_t ux;
    zcoord_t uy;
    pixel_word_t w;
    case (line_zone)
      ZONE_0: begin ux = walk_a;  uy = walk_b;  end
      ZONE_1: begin ux = walk_b;  uy = walk_a;  end
      ZONE_2: begin ux = -walk_b; uy = walk_a;  end
      ZONE_3: begin ux = -walk_a; uy = walk_b;  end
      ZONE_4: begin ux = -walk_a; uy = -walk_b; end
      ZONE_5: begin ux = -walk_b; uy = -walk_a; end
      ZONE_6: begin ux = walk_b;  uy = -walk_a; end
      default: begin ux = walk_a; uy = -walk_b; end
    endcase
    w.shown = 1'b1;
    w.x     = ux[COORD_BITS-1:0];
    w.y     = uy[COORD_BITS-1:0];
    w.ends  = ends;
    return w;
  endfunction

  // expected pixel word for one accepted input word; advances the walker
  function automatic pixel_word_t next_pixel(cmd_t c, coord_t sx, coord_t sy,
                                             coord_t ex, coord_t ey);
    zcoord_t a1, b1, a2, b2;
    err_t    run;
    err_t    rise;
    pixel_word_t none;
    none = '{1'b0, '0, '0, 1'b0};
    if (c == CMD_LOAD) begin
      line_zone = zone_of(zcoord_t'(ex) - zcoord_t'(sx), zcoord_t'(ey) - zcoord_t'(sy));
      fold_point(line_zone, zcoord_t'(sx), zcoord_t'(sy), a1, b1);
      fold_point(line_zone, zcoord_t'(ex), zcoord_t'(ey), a2, b2);
      run       = err_t'(a2) - err_t'(a1);
      rise      = err_t'(b2) - err_t'(b1);
      decision  = err_t'(2 * rise - run);
      grow_east = err_t'(2 * rise);
      grow_ne   = err_t'(2 * (rise - run));
      walk_a    = a1;
      walk_b    = b1;
      walk_stop = a2;
      line_open = walk_a < walk_stop;
      work_words++;
      loads_seen++;
      zone_hits[line_zone]++;
      return current_pixel(!line_open);
    end
    if (!line_open) begin
      idle_steps++;
      return none;
    end
    // east when the decision term is negative, northeast otherwise
    walk_a = walk_a + zcoord_t'(1);
    if (decision < 0) begin
      decision = decision + grow_east;
    end else begin
      walk_b   = walk_b + zcoord_t'(1);
      decision = decision + grow_ne;
    end
    line_open = walk_a < walk_stop;
    work_words++;
    return current_pixel(!line_open);
  endfunction

  function automatic int idle_gap();
    return idle_on ? int'($urandom_range(0, 14)) : 0;
  endfunction

  // random coordinate, with the two extremes drawn more often
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 15))
      0: return coord_t'(COORD_MIN);
      1: return coord_t'(COORD_MAX);
      default: return coord_t'($urandom_range(0, (1 << COORD_BITS) - 1));
    endcase
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  function automatic int walk_length(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int mx;
    int my;
    mx = int'(ex) - int'(sx);
    my = int'(ey) - int'(sy);
    if (mx < 0) mx = -mx;
    if (my < 0) my = -my;
    return (mx > my) ? mx : my;
  endfunction

  // send one input word; valid is kept high straight into the next word when no gap is drawn
  task automatic send_word(input cmd_t c, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    start_x  <= sx;
    start_y  <= sy;
    end_x    <= ex;
    end_y    <= ey;
    do @(posedge clk); while (!in_ready);
    expected_pixels.push_back(next_pixel(c, sx, sy, ex, ey));
  endtask

  // load a line, then give it a number of steps with junk endpoint fields
  task automatic walk_line(input coord_t sx, input coord_t sy, input coord_t ex,
                           input coord_t ey, input int steps);
    send_word(CMD_LOAD, sx, sy, ex, ey);
    repeat (steps) send_word(CMD_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic test_idle_step();
    send_word(CMD_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // single-point lines at both corners, and a step after one of them
  task automatic test_single_point();
    walk_line(coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MIN),
              coord_t'(COORD_MIN), 1);
    walk_line(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
              coord_t'(COORD_MAX), 0);
  endtask

  // one short line per octant, walked to its end, diagonal ties included
  task automatic test_octant_walks();
    int vec_x[8] = '{1, 0, -1, -1, -1, 0, 1, 2};
    int vec_y[8] = '{0, 1, 1, 0, -1, -1, -1, -1};
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    for (int i = 0; i < 8; i++) begin
      sx = coord_t'(100 * i - 400);
      sy = coord_t'(37 - 50 * i);
      ex = coord_t'(int'(sx) + vec_x[i]);
      ey = coord_t'(int'(sy) + vec_y[i]);
      walk_line(sx, sy, ex, ey, walk_length(sx, sy, ex, ey));
    end
  endtask

  // a new load drops a line that is still being walked
  task automatic test_reload_active();
    walk_line(-11'sd500, -11'sd500, 11'sd500, 11'sd300, 1);
    walk_line(coord_t'(COORD_MIN), coord_t'(COORD_MAX), coord_t'(COORD_MIN),
              coord_t'(COORD_MAX), 0);
  endtask

  // full-span diagonals, corner to corner
  task automatic test_extreme_spans();
    walk_line(coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MAX),
              coord_t'(COORD_MAX), 1);
    walk_line(coord_t'(COORD_MAX), coord_t'(COORD_MIN), coord_t'(COORD_MIN),
              coord_t'(COORD_MAX), 1);
  endtask

  // mostly short lines walked to the end, some abandoned, a little noise
  task automatic test_random_lines();
    int goal;
    int kind;
    int span;
    int steps;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    goal = work_words + RANDOM_WORDS;
    while (work_words < goal) begin
      if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
      kind = $urandom_range(0, 99);
      sx   = rand_coord();
      sy   = rand_coord();
      if (kind < 8) begin
        send_word(cmd_t'($urandom_range(0, 1)), sx, sy, rand_coord(), rand_coord());
      end else if (kind < 14) begin
        walk_line(sx, sy, rand_coord(), rand_coord(), $urandom_range(0, 40));
      end else begin
        span  = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 24));
        ex    = clamp_coord(int'(sx) + int'($urandom_range(0, 2 * span)) - span);
        ey    = clamp_coord(int'(sy) + int'($urandom_range(0, 2 * span)) - span);
        steps = walk_length(sx, sy, ex, ey);
        if ($urandom_range(0, 5) == 0) steps = $urandom_range(0, steps);
        else steps = steps + int'($urandom_range(0, 2));
        walk_line(sx, sy, ex, ey, steps);
      end
    end
  endtask

  // result side: draw a stall per word, then take the next one
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = idle_gap();
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fault_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // compare each accepted pixel word with the oldest expectation
  always @(posedge clk) begin
    pixel_word_t want;
    if (out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected pixel word, expected none, got valid=%0b x=%0d y=%0d last=%0b",
                 $time, pix_valid, pix_x, pix_y, pix_last);
      end else begin
        want = expected_pixels.pop_front();
        check_field("pix_valid", int'(want.shown), int'(pix_valid));
        check_field("pix_x", int'(want.x), int'(pix_x));
        check_field("pix_y", int'(want.y), int'(pix_y));
        check_field("pix_last", int'(want.ends), int'(pix_last));
        pixels_checked++;
        if (want.ends) ends_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               expected_pixels.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int zones_covered;
    zones_covered = 0;
    foreach (zone_hits[i]) zone_hits[i] = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_idle_step();
    test_single_point();
    test_octant_walks();
    test_reload_active();
    test_extreme_spans();
    test_random_lines();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    foreach (zone_hits[i]) if (zone_hits[i] > 0) zones_covered++;
    $display("covered %0d line loads over %0d of 8 octants and %0d steps with no line",
             loads_seen, zones_covered, idle_steps);
    $display("checked %0d pixel words, %0d of them line ends", pixels_checked, ends_checked);
    if (fault_count == 0 && expected_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/mlr_pkg.sv
sv/mlr_front.sv
sv/mlr_queue.sv
sv/mlr_back.sv
sv/midpoint_line_rasterizer.sv
dv/tb_midpoint_line_rasterizer.sv
